>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file; all assume clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define EBG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression never true at a clock edge outside reset
`define EBG_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> hw/rtl/ebg_pkg.sv
// ----------------------------------------------------------------------------
// ebg_pkg
// Shared types, codes and constants of the embedding bag gather engine.
// ----------------------------------------------------------------------------
package ebg_pkg;

	localparam int EMB_DIM_DEF  = 16;
	localparam int NUM_ROWS_DEF = 1024;

	localparam int VAL_W  = 16;
	localparam int ACC_W  = 40;
	localparam int PROD_W = 32;
	localparam int SUM_W  = 32;
	localparam int DIM_W  = 7;
	localparam int ROW_W  = 10;
	localparam int COL_W  = 6;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd16;

	// register select bit of the configuration port (word address bit)
	localparam logic REG_USE_BIAS   = 1'b0;
	localparam logic REG_DIM_IN_USE = 1'b1;

	typedef enum logic [1:0] {
		REQ_LOAD_TABLE = 2'd0,
		REQ_LOAD_BIAS  = 2'd1,
		REQ_TOKEN      = 2'd2,
		REQ_END_BAG    = 2'd3
	} req_t;

	// Q4.12 bias widened into the Q16.24 accumulator
	function automatic logic [ACC_W-1:0] bias_to_acc(input logic [VAL_W-1:0] b);
		bias_to_acc = {{(ACC_W-VAL_W-12){b[VAL_W-1]}}, b, 12'b0};
	endfunction

	// accumulator plus product, clamped at the 40-bit signed bounds
	function automatic logic [ACC_W-1:0] mac_sat(input logic [ACC_W-1:0] a,
			input logic [PROD_W-1:0] p);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {{(ACC_W+1-PROD_W){p[PROD_W-1]}}, p};
		if (s[ACC_W] != s[ACC_W-1]) begin
			mac_sat = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			mac_sat = s[ACC_W-1:0];
		end
	endfunction

	// true when the accumulator does not fit the Q8.24 output
	function automatic logic out_of_range(input logic [ACC_W-1:0] a);
		out_of_range = !((&a[ACC_W-1:SUM_W-1]) || !(|a[ACC_W-1:SUM_W-1]));
	endfunction

endpackage

>>> hw/rtl/ebg_ram.sv
// ----------------------------------------------------------------------------
// ebg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ebg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/embedding_bag_gather.sv
// ----------------------------------------------------------------------------
// embedding_bag_gather
// Weighted embedding bag sum: table and bias loads, gather of weighted rows
// into a per-element accumulator, saturated Q8.24 vector output.
// ----------------------------------------------------------------------------
// A load item is written as it is taken and the block stays ready. The first
// token or empty-bag item of a bag first sweeps the bias, or zero when bias
// is off, into the accumulator memory. A token whose row is in range then
// gathers the d elements in use one per cycle through the table and
// accumulator memory ports. Output drains one element per cycle, when the
// receiver does not stall, from the accumulator read port into the output
// register. in_stall stays high while an item is at work.
module embedding_bag_gather import ebg_pkg::*; #(
	parameter int EMB_DIM  = EMB_DIM_DEF,
	parameter int NUM_ROWS = NUM_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic [ROW_W-1:0]          row_index,
	input  logic [COL_W-1:0]          column,
	input  logic signed [VAL_W-1:0]   value,
	input  logic                      last_of_bag,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COL_W-1:0]          element_index,
	output logic signed [SUM_W-1:0]   sum_value,
	output logic                      saturated,
	output logic                      last
);

	localparam int IW     = (EMB_DIM > 1) ? $clog2(EMB_DIM) : 1;
	localparam int CW     = $clog2(EMB_DIM + 1);
	localparam int TDEPTH = NUM_ROWS * EMB_DIM;
	localparam int TAW    = $clog2(TDEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_INIT_DRAIN,
		ST_ACC,
		ST_ACC_DRAIN,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic             use_bias_q;
	logic [DIM_W-1:0] dim_q;
	logic             bag_open_q;
	logic             gather_q;
	logic             emit_q;
	logic [CW-1:0]    cnt_q;
	logic [TAW-1:0]   tbl_ptr_q;
	logic signed [VAL_W-1:0] w_q;
	logic             pend_q;
	logic [IW-1:0]    pend_idx_q;
	logic             out_valid_q;

	logic             init_v_s1;
	logic             mac_v_s1;
	logic [IW-1:0]    idx_s1;
	logic             mac_v_s2;
	logic [IW-1:0]    idx_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [ACC_W-1:0] accv_s2;

	logic             accept_in;
	logic             cfg_we;
	logic [31:0]      row_base;
	logic             row_ok;
	logic             col_ok;
	logic [CW-1:0]    d_eff;
	logic             init_issue;
	logic             acc_issue;
	logic             emit_move;
	logic             emit_issue;
	logic             emit_done;

	logic             tbl_we;
	logic [TAW-1:0]   tbl_waddr;
	logic [VAL_W-1:0] tbl_rdata;
	logic             bias_we;
	logic [VAL_W-1:0] bias_rdata;
	logic             acc_we;
	logic [IW-1:0]    acc_waddr;
	logic [ACC_W-1:0] acc_wdata;
	logic             acc_re;
	logic [ACC_W-1:0] acc_rdata;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_DIM_IN_USE) ? {{(PDATA_W-DIM_W){1'b0}}, dim_q}
		: {{(PDATA_W-1){1'b0}}, use_bias_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_bias_q <= 1'b0;
			dim_q      <= DIM_RESET;
		end else if (cfg_we) begin
			if (paddr[2] == REG_DIM_IN_USE) begin
				dim_q <= pwdata[DIM_W-1:0];
			end else begin
				use_bias_q <= pwdata[0];
			end
		end
	end

	// decode
	assign accept_in = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign row_base  = 32'(row_index) * 32'(EMB_DIM);
	assign row_ok    = 32'(row_index) < 32'(NUM_ROWS);
	assign col_ok    = 7'(column) < 7'(EMB_DIM);

	always_comb begin
		if (dim_q == '0) begin
			d_eff = CW'(1);
		end else if (dim_q > DIM_W'(EMB_DIM)) begin
			d_eff = CW'(EMB_DIM);
		end else begin
			d_eff = CW'(dim_q);
		end
	end

	assign init_issue = (state_q == ST_INIT);
	assign acc_issue  = (state_q == ST_ACC);
	assign emit_move  = pend_q && (!out_valid_q || !out_stall);
	assign emit_issue = (state_q == ST_EMIT) && (cnt_q < d_eff) && (!pend_q || emit_move);
	assign emit_done  = (state_q == ST_EMIT) && (cnt_q == d_eff) && !pend_q;

	// memories
	assign tbl_we    = accept_in && (req_type == REQ_LOAD_TABLE) && row_ok && col_ok;
	assign tbl_waddr = TAW'(row_base + 32'(column));

	ebg_ram #(.WIDTH(VAL_W), .DEPTH(TDEPTH)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (value),
		.re    (acc_issue),
		.raddr (tbl_ptr_q),
		.rdata (tbl_rdata)
	);

	assign bias_we = accept_in && (req_type == REQ_LOAD_BIAS) && col_ok;

	ebg_ram #(.WIDTH(VAL_W), .DEPTH(EMB_DIM)) u_bias (
		.clk   (clk),
		.we    (bias_we),
		.waddr (column[IW-1:0]),
		.wdata (value),
		.re    (init_issue),
		.raddr (cnt_q[IW-1:0]),
		.rdata (bias_rdata)
	);

	// init and multiply-accumulate writes never overlap: a drain state sits between
	assign acc_we    = mac_v_s2 || init_v_s1;
	assign acc_waddr = mac_v_s2 ? idx_s2 : idx_s1;
	assign acc_wdata = mac_v_s2 ? mac_sat(accv_s2, prod_s2)
		: (use_bias_q ? bias_to_acc(bias_rdata) : '0);
	assign acc_re    = acc_issue || emit_issue;

	ebg_ram #(.WIDTH(ACC_W), .DEPTH(EMB_DIM)) u_acc (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.re    (acc_re),
		.raddr (cnt_q[IW-1:0]),
		.rdata (acc_rdata)
	);

	// datapath pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_v_s1 <= 1'b0;
			mac_v_s1  <= 1'b0;
			mac_v_s2  <= 1'b0;
		end else begin
			init_v_s1 <= init_issue;
			mac_v_s1  <= acc_issue;
			mac_v_s2  <= mac_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q[IW-1:0];
		idx_s2  <= idx_s1;
		prod_s2 <= PROD_W'(w_q * $signed(tbl_rdata));
		accv_s2 <= acc_rdata;
	end

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			bag_open_q    <= 1'b0;
			gather_q      <= 1'b0;
			emit_q        <= 1'b0;
			cnt_q         <= '0;
			tbl_ptr_q     <= '0;
			w_q           <= '0;
			pend_q        <= 1'b0;
			pend_idx_q    <= '0;
			out_valid_q   <= 1'b0;
			element_index <= '0;
			sum_value     <= '0;
			saturated     <= 1'b0;
			last          <= 1'b0;
		end else begin
			if (emit_move) begin
				out_valid_q   <= 1'b1;
				element_index <= COL_W'(pend_idx_q);
				saturated     <= out_of_range(acc_rdata);
				last          <= (CW'(pend_idx_q) == d_eff - CW'(1));
				if (out_of_range(acc_rdata)) begin
					sum_value <= acc_rdata[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
						: {1'b0, {(SUM_W-1){1'b1}}};
				end else begin
					sum_value <= acc_rdata[SUM_W-1:0];
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (emit_issue) begin
				pend_q     <= 1'b1;
				pend_idx_q <= cnt_q[IW-1:0];
			end else if (emit_move) begin
				pend_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept_in && (req_type == REQ_TOKEN || req_type == REQ_END_BAG)) begin
						gather_q  <= (req_type == REQ_TOKEN) && row_ok;
						emit_q    <= (req_type == REQ_END_BAG) || last_of_bag;
						w_q       <= value;
						tbl_ptr_q <= TAW'(row_base);
						cnt_q     <= '0;
						if (!bag_open_q) begin
							bag_open_q <= 1'b1;
							state_q    <= ST_INIT;
						end else if ((req_type == REQ_TOKEN) && row_ok) begin
							state_q <= ST_ACC;
						end else if ((req_type == REQ_END_BAG) || last_of_bag) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_INIT: begin
					if (cnt_q == CW'(EMB_DIM - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_INIT_DRAIN;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_INIT_DRAIN: begin
					// wait for the last bias element to land before reading back
					if (!init_v_s1) begin
						if (gather_q) begin
							state_q <= ST_ACC;
						end else if (emit_q) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ACC: begin
					tbl_ptr_q <= tbl_ptr_q + TAW'(1);
					if (cnt_q == d_eff - CW'(1)) begin
						cnt_q   <= '0;
						state_q <= ST_ACC_DRAIN;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_ACC_DRAIN: begin
					if (!mac_v_s1 && !mac_v_s2) begin
						state_q <= emit_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (emit_done) begin
						bag_open_q <= 1'b0;
						cnt_q      <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/ebg_checker.sv
// ----------------------------------------------------------------------------
// ebg_checker
// Port-level checks of the embedding bag gather engine, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ebg_checker import ebg_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic [1:0]              req_type,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [COL_W-1:0]        element_index,
	input logic signed [SUM_W-1:0] sum_value,
	input logic                    saturated,
	input logic                    last
);

	logic in_acc;
	logic out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// stalled result holds
	`EBG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(sum_value)
		&& $stable(element_index) && $stable(saturated) && $stable(last),
		"stalled result changed")

	// loads complete in the cycle they are taken
	`EBG_ASSERT(a_load_free, in_acc && (req_type == REQ_LOAD_TABLE
		|| req_type == REQ_LOAD_BIAS) |=> !in_stall, "load item left the block busy")

	// an end-of-bag item always produces output, so the block must go busy
	`EBG_ASSERT(a_end_busy, in_acc && req_type == REQ_END_BAG |=> in_stall,
		"end of bag did not start output")

	// more elements of the vector follow, so input stays held off
	`EBG_ASSERT(a_vec_busy, out_acc && !last |=> in_stall,
		"input taken in the middle of an output vector")

endmodule

bind embedding_bag_gather ebg_checker u_ebg_checker (.*);

>>> sim/ebg_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebg_check_pkg
// Scoreboard for the embedding bag gather test: keeps its own copy of the
// table, bias and accumulator, predicts every output vector and checks it.
// ----------------------------------------------------------------------------
package ebg_check_pkg;
	import ebg_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_USE_BIAS   = {REG_USE_BIAS, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_DIM_IN_USE = {REG_DIM_IN_USE, 2'b00};

	localparam int ROWS = NUM_ROWS_DEF;
	localparam int DIM  = EMB_DIM_DEF;

	// 40-bit signed accumulator bounds and 32-bit signed output bounds
	localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint OUT_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint OUT_LO = -OUT_HI - 1;

	typedef struct packed {
		logic [COL_W-1:0]        elem;
		logic signed [SUM_W-1:0] total;
		logic                    sat;
		logic                    tail;
	} bag_element_t;

	class bag_sum_scoreboard;
		logic signed [VAL_W-1:0] row_words [ROWS][DIM];
		bit                      row_written [ROWS][DIM];
		logic signed [VAL_W-1:0] bias_words [DIM];
		bit                      bias_written [DIM];
		longint                  acc [DIM];
		bit                      bag_active;
		bit                      use_bias;
		logic [DIM_W-1:0]        dim_reg;
		bag_element_t            expected_sums [$];
		int                      errors;
		int                      items_taken;
		int                      elements_checked;
		int                      saturated_seen;
		int                      bags_closed;

		function new();
			bag_active = 1'b0;
			use_bias = 1'b0;
			dim_reg = DIM_RESET;
		endfunction

		function void config_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
			if (addr == ADDR_USE_BIAS) begin
				use_bias = data[0];
			end else if (addr == ADDR_DIM_IN_USE) begin
				dim_reg = data[DIM_W-1:0];
			end
		endfunction

		// zero acts as one, anything above the built width as the full width
		function int active_dim();
			int d;
			d = int'(dim_reg);
			if (d < 1) d = 1;
			if (d > DIM) d = DIM;
			return d;
		endfunction

		function bit row_ready(int r);
			for (int j = 0; j < active_dim(); j++) begin
				if (!row_written[r][j]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function int pending();
			return expected_sums.size();
		endfunction

		function void open_bag();
			for (int j = 0; j < DIM; j++) begin
				acc[j] = use_bias ? longint'(bias_words[j]) * 4096 : 0;
			end
			bag_active = 1'b1;
		endfunction

		function void gather_row(int r, logic signed [VAL_W-1:0] weight);
			longint s;
			for (int j = 0; j < active_dim(); j++) begin
				s = acc[j] + longint'(weight) * longint'(row_words[r][j]);
				if (s > ACC_HI) s = ACC_HI;
				else if (s < ACC_LO) s = ACC_LO;
				acc[j] = s;
			end
		endfunction

		function void emit_sums();
			bag_element_t e;
			longint a;
			int d;
			d = active_dim();
			for (int j = 0; j < d; j++) begin
				a = acc[j];
				e.sat = 1'b0;
				if (a > OUT_HI) begin
					a = OUT_HI;
					e.sat = 1'b1;
				end else if (a < OUT_LO) begin
					a = OUT_LO;
					e.sat = 1'b1;
				end
				e.elem = j[COL_W-1:0];
				e.total = a[SUM_W-1:0];
				e.tail = (j == d - 1);
				expected_sums.push_back(e);
			end
			bag_active = 1'b0;
			bags_closed++;
		endfunction

		function void take_request(req_t kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
				logic signed [VAL_W-1:0] val, logic lastb);
			items_taken++;
			case (kind)
				REQ_LOAD_TABLE: begin
					if (int'(row) < ROWS && int'(col) < DIM) begin
						row_words[row][col] = val;
						row_written[row][col] = 1'b1;
					end
				end
				REQ_LOAD_BIAS: begin
					if (int'(col) < DIM) begin
						bias_words[col] = val;
						bias_written[col] = 1'b1;
					end
				end
				default: begin
					if (!bag_active) open_bag();
					if (kind == REQ_END_BAG) begin
						emit_sums();
					end else begin
						if (int'(row) < ROWS) gather_row(int'(row), val);
						if (lastb) emit_sums();
					end
				end
			endcase
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $time, what);
			errors++;
		endtask

		task check_element(logic [COL_W-1:0] elem, logic signed [SUM_W-1:0] total, logic sat,
				logic tail);
			bag_element_t want;
			if (expected_sums.size() == 0) begin
				report_mismatch($sformatf("element %0d sum %0d with nothing expected", elem, total));
				return;
			end
			want = expected_sums.pop_front();
			elements_checked++;
			if (sat === 1'b1) saturated_seen++;
			if (elem !== want.elem)
				report_mismatch($sformatf("element_index %0d, want %0d", elem, want.elem));
			if (total !== want.total)
				report_mismatch($sformatf("element %0d sum_value %0d, want %0d",
					want.elem, total, want.total));
			if (sat !== want.sat)
				report_mismatch($sformatf("element %0d saturated %b, want %b",
					want.elem, sat, want.sat));
			if (tail !== want.tail)
				report_mismatch($sformatf("element %0d last %b, want %b", want.elem, tail, want.tail));
		endtask
	endclass

endpackage

>>> sim/embedding_bag_gather_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// embedding_bag_gather_test
// Drives loads, weighted tokens and empty bags into the gather engine under
// several bias and dimension settings and random idling on both sides, and
// checks every output element against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module embedding_bag_gather_test;
	import ebg_pkg::*;
	import ebg_check_pkg::*;

	localparam int CYCLE_LIMIT     = 500000;
	localparam int SETTLE_CYCLES   = 64;
	localparam int HOLD_CYCLES     = 300;
	localparam int LONG_BAG_TOKENS = 6;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [PADDR_W-1:0]      paddr = ADDR_USE_BIAS;
	logic [PDATA_W-1:0]      pwdata = '0;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [1:0]              req_type = REQ_LOAD_TABLE;
	logic [ROW_W-1:0]        row_index = '0;
	logic [COL_W-1:0]        column = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    last_of_bag = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [COL_W-1:0]        element_index;
	logic signed [SUM_W-1:0] sum_value;
	logic                    saturated;
	logic                    last;

	bag_sum_scoreboard sb;
	int send_idle = 31;
	int recv_idle = 80;
	bit hold_out = 1'b0;
	int cycle_count = 0;
	int known_rows [$];

	embedding_bag_gather DUT (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d elements outstanding", cycle_count, sb.pending());
			$display("embedding_bag_gather_test: FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= hold_out || ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_request(req_t'(req_type), row_index, column, value, last_of_bag);
			if (out_valid && !out_stall)
				sb.check_element(element_index, sum_value, saturated, last);
		end
	end

	function automatic logic [VAL_W-1:0] rand_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(19))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2: v = 16'h0000;
			3: v = 16'hFFFF;
			default: v = VAL_W'($urandom);
		endcase
		return v;
	endfunction

	// starts and ends at a falling edge; valid stays up between back-to-back items
	task automatic send_item(input req_t kind, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val, input logic lastb);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		row_index <= row;
		column <= col;
		value <= val;
		last_of_bag <= lastb;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] mask;
		mask = (addr == ADDR_DIM_IN_USE) ? 32'h7F : 32'h1;
		// an item with no result may still be in flight
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.config_write(addr, data);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (data & mask))
			sb.report_mismatch($sformatf("register at %0d reads %0h, want %0h", addr, prdata, data));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic int pick_ready_row();
		int n;
		int start;
		n = known_rows.size();
		if (n == 0) return -1;
		start = $urandom_range(n - 1);
		for (int k = 0; k < n; k++) begin
			if (sb.row_ready(known_rows[(start + k) % n])) return known_rows[(start + k) % n];
		end
		return -1;
	endfunction

	// loads whatever columns of a row the current dimension still lacks
	task automatic fill_row(output int row, inout int done);
		int d;
		d = sb.active_dim();
		if (known_rows.size() > 0 && $urandom_range(1)) begin
			row = known_rows[$urandom_range(known_rows.size() - 1)];
		end else begin
			row = $urandom_range(ROWS - 1);
			known_rows.push_back(row);
		end
		for (int c = 0; c < d; c++) begin
			if (!sb.row_written[row][c]) begin
				send_item(REQ_LOAD_TABLE, ROW_W'(row), COL_W'(c), rand_value(), 1'($urandom));
				done++;
			end
		end
	endtask

	task automatic fill_bias();
		for (int c = 0; c < DIM; c++) begin
			if (!sb.bias_written[c])
				send_item(REQ_LOAD_BIAS, ROW_W'($urandom), COL_W'(c),
					(c == 0) ? 16'h8000 : (c == DIM - 1) ? 16'h7FFF : rand_value(),
					1'($urandom));
		end
	endtask

	task automatic run_directed();
		known_rows.push_back(0);
		known_rows.push_back(ROWS - 1);
		send_item(REQ_LOAD_TABLE, 10'd0, 6'd0, 16'h7FFF, 1'b0);
		send_item(REQ_LOAD_TABLE, 10'd0, 6'd1, 16'h8000, 1'b1);
		send_item(REQ_LOAD_TABLE, 10'd1023, 6'd0, 16'h8000, 1'b0);
		send_item(REQ_LOAD_TABLE, 10'd1023, 6'd1, 16'h0001, 1'b1);
		// columns past the built width are dropped
		send_item(REQ_LOAD_TABLE, 10'd512, 6'd63, 16'h5A5A, 1'b0);
		send_item(REQ_LOAD_BIAS, 10'd1023, 6'd16, 16'hA5A5, 1'b1);
		send_item(REQ_TOKEN, 10'd0, 6'd63, 16'h7FFF, 1'b0);
		send_item(REQ_TOKEN, 10'd1023, 6'd0, 16'h8000, 1'b1);
		// empty bag with nothing open, then closing an open bag
		send_item(REQ_END_BAG, 10'd0, 6'd0, 16'h0000, 1'b0);
		send_item(REQ_TOKEN, 10'd0, 6'd0, 16'h8000, 1'b0);
		send_item(REQ_END_BAG, 10'd1023, 6'd63, 16'hFFFF, 1'b1);
		// three full-scale products push both elements past the output range
		for (int k = 0; k < 3; k++)
			send_item(REQ_TOKEN, 10'd0, 6'd0, 16'h7FFF, k == 2);
		send_item(REQ_TOKEN, 10'd1023, 6'd0, 16'h0000, 1'b1);
	endtask

	// one bag of full-scale products that drives the sum far past the output range
	task automatic run_long_bag();
		for (int k = 0; k < LONG_BAG_TOKENS; k++)
			send_item(REQ_TOKEN, 10'd1023, COL_W'($urandom), 16'h8000,
				k == LONG_BAG_TOKENS - 1);
	endtask

	task automatic run_mix(input int n_items);
		int done;
		int pick;
		int row;
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_item($urandom_range(1) ? REQ_LOAD_TABLE : REQ_LOAD_BIAS, ROW_W'($urandom),
					COL_W'($urandom_range(63, DIM)), VAL_W'($urandom), 1'($urandom));
			end else if (pick < 24) begin
				send_item(REQ_LOAD_TABLE, ROW_W'($urandom), COL_W'($urandom_range(DIM - 1)),
					rand_value(), 1'($urandom));
				done++;
			end else if (pick < 28) begin
				send_item(REQ_LOAD_BIAS, ROW_W'($urandom), COL_W'($urandom_range(DIM - 1)),
					rand_value(), 1'($urandom));
				done++;
			end else if (pick < 34) begin
				send_item(REQ_END_BAG, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom),
					1'($urandom));
				done++;
			end else begin
				row = pick_ready_row();
				if (row < 0 || $urandom_range(9) == 0) fill_row(row, done);
				send_item(REQ_TOKEN, ROW_W'(row), COL_W'($urandom), rand_value(),
					$urandom_range(99) < 30);
				done++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 31;
		recv_idle = 80;
		write_reg(ADDR_DIM_IN_USE, 32'd2);
		run_directed();
		write_reg(ADDR_DIM_IN_USE, 32'd0);
		run_long_bag();
		wait_drained();
		fill_bias();
		write_reg(ADDR_USE_BIAS, 32'd1);
		write_reg(ADDR_DIM_IN_USE, 32'd3);
		send_item(REQ_END_BAG, 10'd0, 6'd0, 16'h0000, 1'b0);
		run_mix(15);

		send_idle = 80;
		recv_idle = 31;
		write_reg(ADDR_USE_BIAS, 32'd0);
		write_reg(ADDR_DIM_IN_USE, 32'd64);
		run_mix(20);

		send_idle = 0;
		recv_idle = 0;
		write_reg(ADDR_USE_BIAS, 32'd1);
		write_reg(ADDR_DIM_IN_USE, 32'd1);
		fork
			begin
				repeat (30) @(posedge clk);
				hold_out = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end
			run_mix(30);
		join

		write_reg(ADDR_USE_BIAS, 32'd0);
		write_reg(ADDR_DIM_IN_USE, 32'd127);
		run_mix(10);
		wait_drained();
		run_mix(10);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("ran %0d items through %0d bags, %0d elements checked, %0d of them saturated",
			sb.items_taken, sb.bags_closed, sb.elements_checked, sb.saturated_seen);
		$display("dimension settings 0, 1, 2, 3, 64, 127 with and without bias, %0d mismatches",
			sb.errors);
		if (sb.errors == 0) begin
			$display("embedding_bag_gather_test: PASS");
		end else begin
			$display("embedding_bag_gather_test: FAIL");
		end
		$finish;
	end

endmodule

>>> embedding_bag_gather.f
+incdir+hw/rtl
hw/rtl/ebg_pkg.sv
hw/rtl/ebg_ram.sv
hw/rtl/embedding_bag_gather.sv
hw/rtl/ebg_checker.sv
sim/ebg_check_pkg.sv
sim/embedding_bag_gather_test.sv
